@@ rtl/cnb_pkg.sv @@
package cnb_pkg;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned ROW_W  = 8;
    localparam int unsigned VALS_W = 32;
    localparam int unsigned LAB_W  = 3;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned SCORE_W = 20;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHANGE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREDICT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_ROW    = 2'd1;
    localparam logic [STAT_W-1:0] ST_DOMAIN = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] REG_FEATURES = 2'd0;
    localparam logic [1:0] REG_CLASSES  = 2'd1;
    localparam logic [1:0] REG_DOMAINS  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ROW_W-1:0]  row_index;
        logic [VALS_W-1:0] feature_values;
        logic [LAB_W-1:0]  class_label;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [LAB_W-1:0]         predicted_class;
        logic                     no_class;
        logic signed [SCORE_W-1:0] best_score;
    } t_result;

endpackage

@@ rtl/cnb_ram.sv @@
module cnb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/cnb_front.sv @@
// Accepts commands, checks domains, row range and store capacity, and queues a decoded job.
module cnb_front
    import cnb_pkg::*;
#(
    parameter int unsigned MAX_FEATURES = 8,
    parameter int unsigned MAX_VALUES   = 16,
    parameter int unsigned MAX_CLASSES  = 8,
    parameter int unsigned MAX_ROWS     = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_cmd          i_cmd,
    output logic          o_busy,
    input  logic [3:0]    i_fc,
    input  logic [3:0]    i_cc,
    input  logic [31:0]   i_domains,
    input  logic [$clog2(MAX_ROWS+1)-1:0] i_row_total,
    output logic          o_job_valid,
    output t_cmd          o_job,
    output logic [STAT_W-1:0] o_job_status,
    input  logic          i_job_take
);
    logic [3:0] fc_eff;
    logic [3:0] cc_eff;
    logic       vals_ok;
    logic [STAT_W-1:0] stat;
    logic [4:0] dom;

    logic              r_full;
    t_cmd              r_job;
    logic [STAT_W-1:0] r_stat;
    logic              r_pend;

    always_comb begin
        fc_eff = (i_fc == 4'd0) ? 4'd1 :
                 (i_fc > 4'(MAX_FEATURES)) ? 4'(MAX_FEATURES) : i_fc;
        cc_eff = (i_cc == 4'd0) ? 4'd1 :
                 (i_cc > 4'(MAX_CLASSES)) ? 4'(MAX_CLASSES) : i_cc;
        vals_ok = 1'b1;
        for (int f = 0; f < MAX_FEATURES; f++) begin
            dom = 5'(i_domains[4*f +: 4]) + 5'd1;
            if (dom > 5'(MAX_VALUES)) dom = 5'(MAX_VALUES);
            if ((4'(f) < fc_eff) && (5'(i_cmd.feature_values[4*f +: 4]) >= dom))
                vals_ok = 1'b0;
        end
        stat = ST_OK;
        unique case (i_cmd.command)
            CMD_APPEND: begin
                if (!vals_ok || (4'(i_cmd.class_label) >= cc_eff)) stat = ST_DOMAIN;
                else if (i_row_total >= ($clog2(MAX_ROWS+1))'(MAX_ROWS)) stat = ST_FULL;
            end
            CMD_CHANGE: begin
                if (($clog2(MAX_ROWS+1)+1)'(i_cmd.row_index) >=
                    ($clog2(MAX_ROWS+1)+1)'(i_row_total)) stat = ST_ROW;
                else if (!vals_ok || (4'(i_cmd.class_label) >= cc_eff)) stat = ST_DOMAIN;
            end
            CMD_PREDICT: begin
                if (!vals_ok) stat = ST_DOMAIN;
            end
            default: stat = ST_OK;
        endcase
    end

    // One job in flight at a time; the queue entry is held until the back end finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                r_full <= 1'b1;
                r_pend <= 1'b1;
            end else begin
                if (i_job_take) r_pend <= 1'b0;
                if (i_job_take) r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_job  <= i_cmd;
            r_stat <= stat;
        end
    end

    assign o_busy       = r_full;
    assign o_job_valid  = r_pend;
    assign o_job        = r_job;
    assign o_job_status = r_stat;
endmodule

@@ rtl/cnb_log.sv @@
// log2 in fixed point: one squaring step per cycle.
module cnb_log
    import cnb_pkg::*;
#(
    parameter int unsigned CNT_W  = 9,
    parameter int unsigned FRAC_W = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_go,
    input  logic [CNT_W-1:0]        i_x,
    output logic                    o_done,
    output logic [FRAC_W+4:0]       o_log
);
    logic               r_run;
    logic [31:0]        r_m;
    logic [FRAC_W+4:0]  r_r;
    logic [4:0]         r_bit;
    logic [3:0]         e;
    logic [63:0]        sq;
    logic [32:0]        sh;

    always_comb begin
        e = 4'd0;
        for (int i = 1; i < CNT_W; i++) begin
            if (i_x[i]) e = 4'(i);
        end
        sq = 64'(r_m) * 64'(r_m);
        sh = 33'(sq >> 30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_m   <= 32'(64'(i_x) << (30 - e));
                r_r   <= (FRAC_W+5)'(e) << FRAC_W;
                r_bit <= 5'(FRAC_W - 1);
            end else if (r_run) begin
                if (sh[31]) begin
                    r_m <= sh[32:1];
                    r_r <= r_r | ((FRAC_W+5)'(1) << r_bit);
                end else begin
                    r_m <= sh[31:0];
                end
                if (r_bit == 5'd0) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
                r_bit <= r_bit - 5'd1;
            end
        end
    end

    assign o_log = r_r;
endmodule

@@ rtl/cnb_back.sv @@
// Carries out jobs: row store and count updates, and the predict walk.
module cnb_back
    import cnb_pkg::*;
#(
    parameter int unsigned MAX_FEATURES = 8,
    parameter int unsigned MAX_VALUES   = 16,
    parameter int unsigned MAX_CLASSES  = 8,
    parameter int unsigned MAX_ROWS     = 256,
    parameter int unsigned FRAC_W       = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_cmd        i_job,
    input  logic [STAT_W-1:0] i_job_status,
    output logic        o_job_take,
    input  logic [3:0]  i_fc,
    input  logic [3:0]  i_cc,
    output logic [$clog2(MAX_ROWS+1)-1:0] o_row_total,
    output logic        o_done,
    output t_result     o_res
);
    localparam int unsigned RT_W  = $clog2(MAX_ROWS+1);
    localparam int unsigned RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CL_W  = $clog2(MAX_CLASSES);
    localparam int unsigned FT_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int unsigned VL_W  = $clog2(MAX_VALUES);
    localparam int unsigned SLOTS = MAX_CLASSES * MAX_FEATURES * MAX_VALUES;
    localparam int unsigned SL_W  = $clog2(SLOTS);
    localparam int unsigned CNT_W = RT_W;
    localparam int unsigned LOG_W = FRAC_W + 5;
    localparam int unsigned ACC_W = LOG_W + 8;
    localparam int unsigned ROW_D = VALS_W + LAB_W;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;
    localparam logic [4:0] S_OLDRD  = 5'd2;
    localparam logic [4:0] S_OLDWT  = 5'd3;
    localparam logic [4:0] S_UPRD   = 5'd4;
    localparam logic [4:0] S_UPWT   = 5'd5;
    localparam logic [4:0] S_UPWR   = 5'd6;
    localparam logic [4:0] S_PCLS   = 5'd7;
    localparam logic [4:0] S_PLN    = 5'd8;
    localparam logic [4:0] S_PRD    = 5'd9;
    localparam logic [4:0] S_PWT    = 5'd10;
    localparam logic [4:0] S_PLK    = 5'd11;
    localparam logic [4:0] S_PEND   = 5'd12;
    localparam logic [4:0] S_OUT    = 5'd13;
    localparam logic [4:0] S_WAITLG = 5'd14;

    logic [4:0]  r_st;
    logic [SL_W:0] r_clr;
    logic [RT_W-1:0] r_total;
    logic [CNT_W-1:0] r_ctot [MAX_CLASSES];

    // Update pass: pass 0 removes the old row (change only), pass 1 adds the new one.
    logic        r_pass;
    logic [VALS_W-1:0] r_vals;
    logic [LAB_W-1:0]  r_lab;
    logic [FT_W:0]     r_f;
    logic [CL_W:0]     r_c;
    logic signed [ACC_W-1:0] r_s;
    logic signed [ACC_W-1:0] r_best;
    logic [LOG_W-1:0]  r_ln;
    logic              r_found;
    logic [LAB_W-1:0]  r_pred;
    t_result           r_res;
    logic              r_done;

    logic              rs_we;
    logic [RA_W-1:0]   rs_waddr, rs_raddr;
    logic [ROW_D-1:0]  rs_wdata, rs_rdata;
    logic              vc_we;
    logic [SL_W-1:0]   vc_waddr, vc_raddr;
    logic [CNT_W-1:0]  vc_wdata, vc_rdata;

    logic              lg_go, lg_done;
    logic [CNT_W-1:0]  lg_x;
    logic [LOG_W-1:0]  lg_out;

    logic [3:0] fc_eff, cc_eff;
    logic [VL_W-1:0] cur_v;
    logic [SL_W-1:0] cur_slot;
    logic signed [ACC_W-1:0] fin;

    cnb_ram #(.WIDTH(ROW_D), .DEPTH(MAX_ROWS)) u_rows (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(rs_waddr), .i_wdata(rs_wdata),
        .i_raddr(rs_raddr), .o_rdata(rs_rdata)
    );

    cnb_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_counts (
        .i_clk(i_clk), .i_we(vc_we), .i_waddr(vc_waddr), .i_wdata(vc_wdata),
        .i_raddr(vc_raddr), .o_rdata(vc_rdata)
    );

    cnb_log #(.CNT_W(CNT_W), .FRAC_W(FRAC_W)) u_log (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(lg_go), .i_x(lg_x),
        .o_done(lg_done), .o_log(lg_out)
    );

    always_comb begin
        fc_eff = (i_fc == 4'd0) ? 4'd1 :
                 (i_fc > 4'(MAX_FEATURES)) ? 4'(MAX_FEATURES) : i_fc;
        cc_eff = (i_cc == 4'd0) ? 4'd1 :
                 (i_cc > 4'(MAX_CLASSES)) ? 4'(MAX_CLASSES) : i_cc;
        cur_v    = VL_W'(r_vals[4*r_f[FT_W-1:0] +: 4]);
        cur_slot = SL_W'(((32'(r_c[CL_W-1:0]) * MAX_FEATURES) + 32'(r_f[FT_W-1:0]))
                   * MAX_VALUES + 32'(cur_v));
        fin = r_s - ($signed(ACC_W'(fc_eff)) * $signed(ACC_W'(r_ln)))
              + $signed(ACC_W'(r_ln));
    end

    always_comb begin
        // A change writes its row only once the old row has been read back.
        rs_we    = ((r_st == S_IDLE) && i_job_valid && (i_job_status == ST_OK) &&
                    (i_job.command == CMD_APPEND)) || (r_st == S_OLDWT);
        rs_waddr = (i_job.command == CMD_APPEND) ? RA_W'(r_total) : RA_W'(i_job.row_index);
        rs_wdata = {i_job.class_label, i_job.feature_values};
        rs_raddr = RA_W'(i_job.row_index);
        vc_we    = (r_st == S_CLR) || (r_st == S_UPWR);
        vc_waddr = (r_st == S_CLR) ? SL_W'(r_clr) : cur_slot;
        vc_wdata = (r_st == S_CLR) ? '0 :
                   r_pass ? vc_rdata + CNT_W'(1) :
                   (vc_rdata != '0) ? vc_rdata - CNT_W'(1) : '0;
        vc_raddr = cur_slot;
        lg_go    = 1'b0;
        lg_x     = vc_rdata;
        if (r_st == S_PLN) begin
            lg_go = 1'b1;
            lg_x  = r_ctot[r_c[CL_W-1:0]];
        end else if (r_st == S_PLK && vc_rdata != '0) begin
            lg_go = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLR;
            r_clr   <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
            for (int c = 0; c < MAX_CLASSES; c++) r_ctot[c] <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (SL_W+1)'(SLOTS-1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_res <= '{status: i_job_status, predicted_class: '0,
                                   no_class: 1'b0, best_score: '0};
                        r_vals <= i_job.feature_values;
                        r_lab  <= i_job.class_label;
                        r_f    <= '0;
                        r_c    <= '0;
                        r_found <= 1'b0;
                        r_s    <= '0;
                        if (i_job_status != ST_OK || i_job.command == CMD_NONE) begin
                            r_st <= S_OUT;
                        end else if (i_job.command == CMD_APPEND) begin
                            r_total <= r_total + 1'b1;
                            r_pass  <= 1'b1;
                            r_st    <= S_UPRD;
                        end else if (i_job.command == CMD_CHANGE) begin
                            r_pass <= 1'b0;
                            r_st   <= S_OLDRD;
                        end else begin
                            r_pass <= 1'b0;
                            r_st   <= S_PCLS;
                        end
                    end
                end
                S_OLDRD: r_st <= S_OLDWT;
                S_OLDWT: begin
                    r_vals <= rs_rdata[VALS_W-1:0];
                    r_c    <= (CL_W+1)'(rs_rdata[ROW_D-1 -: LAB_W]);
                    r_st   <= S_UPRD;
                end
                S_UPRD: begin
                    if (r_f == '0) begin
                        if (!r_pass) r_c <= r_c;
                        else r_c <= r_pass && r_f == '0 && r_st == S_UPRD &&
                                    r_c == '0 ? (CL_W+1)'(r_lab) : r_c;
                    end
                    r_st <= S_UPWT;
                end
                S_UPWT: r_st <= S_UPWR;
                S_UPWR: begin
                    if (r_f == (FT_W+1)'(MAX_FEATURES-1)) begin
                        r_f <= '0;
                        if (r_pass) begin
                            r_ctot[r_c[CL_W-1:0]] <= r_ctot[r_c[CL_W-1:0]] + 1'b1;
                            r_st <= S_OUT;
                        end else begin
                            if (r_ctot[r_c[CL_W-1:0]] != '0)
                                r_ctot[r_c[CL_W-1:0]] <= r_ctot[r_c[CL_W-1:0]] - 1'b1;
                            r_pass <= 1'b1;
                            r_vals <= i_job.feature_values;
                            r_c    <= (CL_W+1)'(r_lab);
                            r_st   <= S_UPRD;
                        end
                    end else begin
                        r_f  <= r_f + 1'b1;
                        r_st <= S_UPRD;
                    end
                end
                S_PCLS: begin
                    r_f <= '0;
                    r_s <= '0;
                    if (r_c >= (CL_W+1)'(cc_eff)) r_st <= S_PEND;
                    else if (r_ctot[r_c[CL_W-1:0]] == '0) r_c <= r_c + 1'b1;
                    else r_st <= S_PLN;
                end
                S_PLN: r_st <= S_WAITLG;
                S_WAITLG: begin
                    if (lg_done) begin
                        if (r_f == '0 && r_s == '0 && r_st == S_WAITLG && !r_pass) begin
                            r_ln   <= lg_out;
                            r_pass <= 1'b1;
                            r_st   <= S_PRD;
                        end else begin
                            r_s <= r_s + ACC_W'(lg_out);
                            if (r_f == (FT_W+1)'(fc_eff) - 1'b1) begin
                                r_st <= S_PEND;
                                r_pass <= 1'b0;
                            end else begin
                                r_f  <= r_f + 1'b1;
                                r_st <= S_PRD;
                            end
                        end
                    end
                end
                S_PRD: r_st <= S_PWT;
                S_PWT: r_st <= S_PLK;
                S_PLK: begin
                    if (vc_rdata == '0) begin
                        r_pass <= 1'b0;
                        r_c  <= r_c + 1'b1;
                        r_st <= S_PCLS;
                    end else begin
                        r_st <= S_WAITLG;
                    end
                end
                S_PEND: begin
                    if (r_c < (CL_W+1)'(cc_eff)) begin
                        if (!r_found || fin > r_best) begin
                            r_found <= 1'b1;
                            r_best  <= fin;
                            r_pred  <= LAB_W'(r_c);
                        end
                        r_c  <= r_c + 1'b1;
                        r_st <= S_PCLS;
                    end else begin
                        r_res <= '{status: r_res.status,
                                   predicted_class: r_found ? r_pred : '0,
                                   no_class: !r_found,
                                   best_score: !r_found ? '0 :
                                       (r_best > ACC_W'(524287)) ? 20'sd524287 :
                                       (r_best < -ACC_W'(524288)) ? -20'sd524288 :
                                       SCORE_W'(r_best)};
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_done <= 1'b1;
                    r_st   <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_job_take  = (r_st == S_OUT);
    assign o_row_total = r_total;
    assign o_done      = r_done;
    assign o_res       = r_res;
endmodule

@@ rtl/categorical_naive_bayes.sv @@
// Categorical naive Bayes classifier.
// Commands enter on i_start/i_cmd and are accepted when o_busy is low: append a
// training row, change a stored row, or predict a class for a feature vector.
// Each command yields one result on o_res, marked by o_done for one cycle; the
// receiver cannot hold it off, so it must take the transfer when it appears.
// Only one command is worked on at a time; o_busy stays high until its result.
// An append does one count read-modify-write per feature slot (eight by default)
// and a change does them twice; a rejected or unused command goes straight to its result.
// Predict walks classes times features through the count memory and a serial log
// unit, one log per lookup; a class with no rows is skipped, and a class is dropped
// at the first feature value with a zero count.
// After reset the block clears its count memory, one entry per cycle, for all
// MAX_CLASSES*MAX_FEATURES*MAX_VALUES entries (1024 by default) and holds o_busy
// high meanwhile; configuration writes over the APB port are taken throughout.
// The row store needs no clearing: only rows below the row total are read.
module categorical_naive_bayes
    import cnb_pkg::*;
#(
    parameter int unsigned MAX_FEATURES      = 8,
    parameter int unsigned MAX_VALUES        = 16,
    parameter int unsigned MAX_CLASSES       = 8,
    parameter int unsigned MAX_ROWS          = 256,
    parameter int unsigned LOG_FRACTION_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_cmd        i_cmd,
    output logic        o_busy,
    output logic        o_done,
    output t_result     o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [3:0]  r_fc, r_cc;
    logic [31:0] r_dom;
    logic        job_valid, job_take, front_busy;
    t_cmd        job;
    logic [STAT_W-1:0] job_status;
    logic [$clog2(MAX_ROWS+1)-1:0] row_total;
    logic        u_back_clearing;
    logic        r_clearing;
    logic [10:0] r_cnt;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc  <= 4'd8;
            r_cc  <= 4'd2;
            r_dom <= 32'hFFFF_FFFF;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_FEATURES: r_fc  <= pwdata[3:0];
                REG_CLASSES:  r_cc  <= pwdata[3:0];
                REG_DOMAINS:  r_dom <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FEATURES: prdata = {28'd0, r_fc};
            REG_CLASSES:  prdata = {28'd0, r_cc};
            REG_DOMAINS:  prdata = r_dom;
            default:      prdata = '0;
        endcase
    end

    cnb_front #(
        .MAX_FEATURES(MAX_FEATURES), .MAX_VALUES(MAX_VALUES),
        .MAX_CLASSES(MAX_CLASSES), .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start && !o_busy), .i_cmd(i_cmd),
        .o_busy(front_busy), .i_fc(r_fc), .i_cc(r_cc), .i_domains(r_dom),
        .i_row_total(row_total), .o_job_valid(job_valid), .o_job(job),
        .o_job_status(job_status), .i_job_take(job_take)
    );

    cnb_back #(
        .MAX_FEATURES(MAX_FEATURES), .MAX_VALUES(MAX_VALUES),
        .MAX_CLASSES(MAX_CLASSES), .MAX_ROWS(MAX_ROWS), .FRAC_W(LOG_FRACTION_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid), .i_job(job),
        .i_job_status(job_status), .o_job_take(job_take), .i_fc(r_fc), .i_cc(r_cc),
        .o_row_total(row_total), .o_done(o_done), .o_res(o_res)
    );

    // The back end is busy while clearing after reset.
    assign o_busy = front_busy || job_take || (!job_valid && u_back_clearing);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clearing <= 1'b1;
        else if (r_cnt == 11'(MAX_CLASSES*MAX_FEATURES*MAX_VALUES)) r_clearing <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else if (r_clearing) r_cnt <= r_cnt + 11'd1;
    end
    assign u_back_clearing = r_clearing;
endmodule

@@ rtl/cnb_checker.sv @@
module cnb_checker
    import cnb_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input logic    o_busy,
    input logic    o_done,
    input t_result o_res
);
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held two cycles");
    a_busy_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy did not rise");
    a_done_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy)) else $error("result without a command");
    a_noclass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.no_class) |-> (o_res.best_score == '0))
        else $error("no class with a score");
endmodule

bind categorical_naive_bayes cnb_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_res(o_res)
);

@@ tb/categorical_naive_bayes_tb.sv @@
`timescale 1ns / 100ps

module categorical_naive_bayes_tb;
    import cnb_pkg::*;

    localparam int N_FEAT   = 8;
    localparam int N_VALS   = 16;
    localparam int N_CLS    = 8;
    localparam int N_ROWS   = 256;
    localparam int FRAC     = 12;
    localparam int WDOG_MAX = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    t_cmd        i_cmd;
    logic        o_busy;
    logic        o_done;
    t_result     o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    categorical_naive_bayes u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Shadow of the classifier: configuration, row store and counts.
    logic [3:0]  cfg_feat;
    logic [3:0]  cfg_cls;
    logic [31:0] cfg_dom;
    logic [31:0] row_vals [N_ROWS];
    logic [2:0]  row_label [N_ROWS];
    int          rows_held;
    int          class_rows [N_CLS];
    int          value_hits [N_CLS][N_FEAT][N_VALS];

    t_cmd    cmd_queue [$];
    t_result outcome_queue [$];

    int errors;
    int n_results;
    int n_scored;
    int n_none;
    int n_status [4];
    int wdog;

    function automatic int eff_feat();
        return (cfg_feat == 0) ? 1 : ((cfg_feat > N_FEAT) ? N_FEAT : cfg_feat);
    endfunction

    function automatic int eff_cls();
        return (cfg_cls == 0) ? 1 : ((cfg_cls > N_CLS) ? N_CLS : cfg_cls);
    endfunction

    function automatic int domain_size(int f);
        return int'(cfg_dom[4*f +: 4]) + 1;
    endfunction

    function automatic bit values_in_domain(logic [31:0] vals);
        for (int f = 0; f < eff_feat(); f++)
            if (int'(vals[4*f +: 4]) >= domain_size(f)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void update_counts(logic [31:0] vals, logic [2:0] lab, bit add);
        int v;
        if (add) class_rows[lab]++;
        else if (class_rows[lab] > 0) class_rows[lab]--;
        for (int f = 0; f < N_FEAT; f++) begin
            v = vals[4*f +: 4];
            if (add) value_hits[lab][f][v]++;
            else if (value_hits[lab][f][v] > 0) value_hits[lab][f][v]--;
        end
    endfunction

    // Fixed-point log2 by repeated squaring of the normalised mantissa.
    function automatic longint log2_fx(int unsigned x);
        int unsigned     e;
        longint unsigned m;
        longint          r;
        e = 0;
        while (e < 31 && (x >> (e + 1)) != 0) e++;
        m = longint'(x) << (30 - e);
        r = longint'(e) << FRAC;
        for (int i = FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                r += longint'(1) << i;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic t_result classify_step(t_cmd c);
        t_result res;
        int      cc, fc, n, k;
        longint  best, s, ln;
        bit      found, ok;
        res = '0;
        cc = eff_cls();
        fc = eff_feat();
        best = 0;
        found = 1'b0;
        case (c.command)
            CMD_APPEND: begin
                if (!values_in_domain(c.feature_values) || c.class_label >= cc)
                    res.status = ST_DOMAIN;
                else if (rows_held >= N_ROWS)
                    res.status = ST_FULL;
                else begin
                    row_vals[rows_held] = c.feature_values;
                    row_label[rows_held] = c.class_label;
                    rows_held++;
                    update_counts(c.feature_values, c.class_label, 1'b1);
                end
            end
            CMD_CHANGE: begin
                if (c.row_index >= rows_held)
                    res.status = ST_ROW;
                else if (!values_in_domain(c.feature_values) || c.class_label >= cc)
                    res.status = ST_DOMAIN;
                else begin
                    update_counts(row_vals[c.row_index], row_label[c.row_index], 1'b0);
                    row_vals[c.row_index] = c.feature_values;
                    row_label[c.row_index] = c.class_label;
                    update_counts(c.feature_values, c.class_label, 1'b1);
                end
            end
            CMD_PREDICT: begin
                if (!values_in_domain(c.feature_values))
                    res.status = ST_DOMAIN;
                else begin
                    for (int cl = 0; cl < cc; cl++) begin
                        n = class_rows[cl];
                        if (n == 0) continue;
                        ln = log2_fx(n);
                        s = 0;
                        ok = 1'b1;
                        for (int f = 0; f < fc && ok; f++) begin
                            k = value_hits[cl][f][c.feature_values[4*f +: 4]];
                            if (k == 0) ok = 1'b0;
                            else s += log2_fx(k);
                        end
                        if (!ok) continue;
                        s = s - longint'(fc) * ln + ln;
                        if (!found || s > best) begin
                            found = 1'b1;
                            best = s;
                            res.predicted_class = cl[2:0];
                        end
                    end
                    if (!found) begin
                        res.no_class = 1'b1;
                        best = 0;
                    end
                end
            end
            default: ;
        endcase
        if (best > 524287) best = 524287;
        if (best < -524288) best = -524288;
        res.best_score = best[SCORE_W-1:0];
        return res;
    endfunction

    // Command driver: bursts of back-to-back commands separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        logic nxt_start;
        t_cmd nxt_cmd;
        nxt_start = i_start;
        nxt_cmd = i_cmd;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            nxt_cmd = '0;
            burst_left = $urandom_range(1, 6);
            gap_left = 0;
        end else if (!(i_start && o_busy)) begin
            if (i_start) outcome_queue = {outcome_queue, classify_step(i_cmd)};
            nxt_start = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (cmd_queue.size() > 0) begin
                nxt_cmd = cmd_queue.pop_front();
                nxt_start = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
                end
            end
        end
        i_start <= nxt_start;
        i_cmd <= nxt_cmd;
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_done) begin
            n_results++;
            if (outcome_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", o_res);
            end else begin
                exp_res = outcome_queue.pop_front();
                n_status[exp_res.status]++;
                if (exp_res.status == ST_OK && exp_res.best_score != 0) n_scored++;
                if (exp_res.no_class) n_none++;
                if (o_res.status !== exp_res.status
                        || o_res.predicted_class !== exp_res.predicted_class
                        || o_res.no_class !== exp_res.no_class
                        || o_res.best_score !== exp_res.best_score) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p, got %p", exp_res, o_res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done)
            wdog <= 0;
        else if (wdog >= WDOG_MAX) begin
            $display("watchdog expired with %0d results outstanding", outcome_queue.size());
            $display("categorical_naive_bayes regression: fail");
            $finish;
        end else
            wdog <= wdog + 1;
    end

    task automatic add_cmd(logic [1:0] op, logic [7:0] row, logic [31:0] vals,
                           logic [2:0] lab);
        t_cmd c;
        c.command = op;
        c.row_index = row;
        c.feature_values = vals;
        c.class_label = lab;
        cmd_queue = {cmd_queue, c};
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || i_start || outcome_queue.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FEATURES: cfg_feat = val[3:0];
            REG_CLASSES:  cfg_cls = val[3:0];
            default:      cfg_dom = val;
        endcase
    endtask

    // Mostly well-formed commands whose values lie in the configured domains,
    // with a share of fully random noise to reach the error paths.
    task automatic random_phase(logic [3:0] fc, logic [3:0] cc, logic [31:0] dom,
                                int count, int append_pct);
        logic [1:0]  op;
        logic [7:0]  row;
        logic [31:0] vals;
        logic [2:0]  lab;
        int          pick, hi;
        reg_write(REG_FEATURES, {28'd0, fc});
        reg_write(REG_CLASSES, {28'd0, cc});
        reg_write(REG_DOMAINS, dom);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < append_pct) op = CMD_APPEND;
            else if (pick < append_pct + 20) op = CMD_CHANGE;
            else if (pick < 96) op = CMD_PREDICT;
            else op = CMD_NONE;
            vals = $urandom;
            lab = 3'($urandom_range(0, eff_cls() - 1));
            hi = (rows_held + 4 > 255) ? 255 : rows_held + 4;
            row = 8'($urandom_range(0, hi));
            if ($urandom_range(0, 9) != 0) begin
                for (int f = 0; f < eff_feat(); f++)
                    vals[4*f +: 4] = 4'($urandom_range(0, domain_size(f) - 1));
            end else begin
                lab = 3'($urandom);
                row = 8'($urandom);
            end
            add_cmd(op, row, vals, lab);
        end
        wait_idle();
    endtask

    initial begin
        cfg_feat = 4'd8;
        cfg_cls = 4'd2;
        cfg_dom = 32'hFFFF_FFFF;
        rows_held = 0;
        foreach (class_rows[c]) class_rows[c] = 0;
        foreach (value_hits[c, f, v]) value_hits[c][f][v] = 0;
        foreach (n_status[s]) n_status[s] = 0;
        errors = 0;
        n_results = 0;
        n_scored = 0;
        n_none = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, unused command, errors, then a small training set with predictions and changes.
        add_cmd(CMD_PREDICT, 8'd0, 32'h0000_0000, 3'd0);
        add_cmd(CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 3'd7);
        add_cmd(CMD_APPEND, 8'd0, 32'h0000_0000, 3'd2);
        add_cmd(CMD_CHANGE, 8'd0, 32'h0000_0000, 3'd0);
        add_cmd(CMD_APPEND, 8'd0, 32'h0000_0000, 3'd0);
        add_cmd(CMD_APPEND, 8'd0, 32'hFFFF_FFFF, 3'd1);
        add_cmd(CMD_APPEND, 8'd0, 32'h1234_5678, 3'd1);
        add_cmd(CMD_APPEND, 8'd0, 32'h0000_0000, 3'd0);
        add_cmd(CMD_PREDICT, 8'd0, 32'h0000_0000, 3'd0);
        add_cmd(CMD_PREDICT, 8'd0, 32'hFFFF_FFFF, 3'd0);
        add_cmd(CMD_PREDICT, 8'd0, 32'h1234_5678, 3'd0);
        add_cmd(CMD_PREDICT, 8'd0, 32'h1111_1111, 3'd0);
        add_cmd(CMD_CHANGE, 8'd1, 32'h0000_0000, 3'd0);
        add_cmd(CMD_CHANGE, 8'd255, 32'h0000_0000, 3'd0);
        add_cmd(CMD_CHANGE, 8'd2, 32'h0000_0000, 3'd5);
        add_cmd(CMD_PREDICT, 8'd0, 32'h0000_0000, 3'd7);
        add_cmd(CMD_PREDICT, 8'd0, 32'hFFFF_FFFF, 3'd0);
        wait_idle();

        random_phase(4'd0, 4'd0, 32'h0000_0000, 60, 40);
        random_phase(4'd2, 4'd3, 32'h1111_1121, 150, 45);
        random_phase(4'd8, 4'd8, 32'h1212_1212, 150, 40);
        random_phase(4'd15, 4'd15, 32'hFFFF_FFFF, 100, 30);
        random_phase(4'd3, 4'd4, 32'h0000_0321, 200, 60);
        random_phase(4'd4, 4'd8, 32'h3333_3333, 150, 30);
        random_phase(4'd1, 4'd2, 32'h0000_0001, 100, 30);

        repeat (50) @(posedge i_clk);
        $display("%0d results: %0d ok, %0d bad row, %0d out of domain, %0d store full",
                 n_results, n_status[ST_OK], n_status[ST_ROW], n_status[ST_DOMAIN],
                 n_status[ST_FULL]);
        $display("%0d predictions with a nonzero score, %0d with no class, %0d rows held",
                 n_scored, n_none, rows_held);
        if (errors == 0 && outcome_queue.size() == 0)
            $display("categorical_naive_bayes regression: pass");
        else
            $display("categorical_naive_bayes regression: fail");
        $finish;
    end

endmodule
